>>> design/rgbenc_pkg.sv
// ----------------------------------------------------------------------------
// rgbenc_pkg: shared types and constants of the RGB565 run-length encoder
// Pixel and byte words, the queue entry between front and back, and CRC-32.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbenc_pkg;

  // Longest run of equal pixels that one count/pixel pair carries
  localparam logic [15:0] MAX_RUN = 16'd65535;

  localparam logic [31:0] CRC32_REFLECTED = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Configuration register byte addresses
  localparam logic [1:0] ADDR_ENCODING_MODE = 2'd0;

  localparam logic MODE_RAW = 1'b0;
  localparam logic MODE_RLE = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        end_of_payload;
    logic [31:0] image_crc;
    logic [31:0] image_length;
  } out_word_t;

  // Bytes that one pixel produces, lowest byte sent first
  typedef struct packed {
    logic [63:0] bytes;
    logic [2:0]  last_idx;
    logic        last;
  } entry_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC32_REFLECTED & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/rgbenc_front.sv
// ----------------------------------------------------------------------------
// rgbenc_front: pixel classifier
// Truncates each pixel to RGB565, tracks the open run and packs the bytes
// that the pixel releases into one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbenc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              encoding_mode,
  input  wire logic              accept,
  input  wire rgbenc_pkg::pixel_t pixel,
  output logic                   push,
  output rgbenc_pkg::entry_t     entry
);

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_RAW  = 2'd1,
    TAIL_RUN  = 2'd2
  } tail_t;

  logic [15:0] run_value;
  logic [15:0] run_count;
  logic [15:0] run_value_next;
  logic [15:0] run_count_next;

  logic [15:0] pix;
  logic        run_open;
  logic        head_valid;
  logic [31:0] head_word;
  tail_t       tail_kind;
  logic [31:0] tail_word;

  assign pix      = {pixel.red[7:3], pixel.green[7:2], pixel.blue[7:3]};
  assign run_open = (run_count != 16'd0);

  always_comb begin
    head_valid     = run_open;
    head_word      = {run_value, run_count};
    tail_kind      = TAIL_NONE;
    run_value_next = run_value;
    run_count_next = run_count;
    if (encoding_mode == rgbenc_pkg::MODE_RAW) begin
      // flush any open run, then the pixel itself
      tail_kind      = TAIL_RAW;
      run_count_next = 16'd0;
    end else if (run_open && pix == run_value && run_count < rgbenc_pkg::MAX_RUN) begin
      head_valid     = pixel.last_pixel;
      head_word      = {run_value, run_count + 16'd1};
      run_count_next = run_count + 16'd1;
    end else begin
      tail_kind      = pixel.last_pixel ? TAIL_RUN : TAIL_NONE;
      run_value_next = pix;
      run_count_next = 16'd1;
    end
    if (pixel.last_pixel) begin
      run_value_next = 16'd0;
      run_count_next = 16'd0;
    end
  end

  always_comb begin
    case (tail_kind)
      TAIL_RAW: tail_word = {16'd0, pix};
      TAIL_RUN: tail_word = {pix, 16'd1};
      default:  tail_word = 32'd0;
    endcase
  end

  always_comb begin
    entry.last = pixel.last_pixel;
    if (head_valid) begin
      entry.bytes = {tail_word, head_word};
      case (tail_kind)
        TAIL_RAW: entry.last_idx = 3'd5;
        TAIL_RUN: entry.last_idx = 3'd7;
        default:  entry.last_idx = 3'd3;
      endcase
    end else begin
      entry.bytes = {32'd0, tail_word};
      case (tail_kind)
        TAIL_RUN: entry.last_idx = 3'd3;
        default:  entry.last_idx = 3'd1;
      endcase
    end
  end

  assign push = accept && (head_valid || tail_kind != TAIL_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value <= 16'd0;
      run_count <= 16'd0;
    end else if (accept) begin
      run_value <= run_value_next;
      run_count <= run_count_next;
    end
  end

endmodule

`default_nettype wire

>>> design/rgbenc_queue.sv
// ----------------------------------------------------------------------------
// rgbenc_queue: entry queue between classifier and byte serializer
// Small register FIFO; full holds off the pixel input.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbenc_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rgbenc_pkg::entry_t push_entry,
  input  wire logic              pop,
  output logic                   head_valid,
  output rgbenc_pkg::entry_t     head_entry,
  output logic                   full,
  output logic                   empty
);

  localparam int AW = rgbenc_pkg::QUEUE_AW;
  localparam int DEPTH = rgbenc_pkg::QUEUE_DEPTH;

  rgbenc_pkg::entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   level;

  assign empty      = (level == (AW+1)'(0));
  assign full       = (level == (AW+1)'(DEPTH));
  assign head_valid = !empty;
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + (AW+1)'(1);
        2'b01:   level <= level - (AW+1)'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/rgbenc_back.sv
// ----------------------------------------------------------------------------
// rgbenc_back: byte serializer
// Sends one byte per cycle from the current entry while not stalled, keeps
// the running CRC-32 and byte count, and closes the image on its final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbenc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire rgbenc_pkg::entry_t head_entry,
  output logic                   pop,
  output logic                   out_valid,
  output rgbenc_pkg::out_word_t  out_data,
  input  wire logic              out_stall
);

  rgbenc_pkg::entry_t work;
  logic        work_valid;
  logic [2:0]  idx;
  logic [31:0] crc;
  logic [31:0] count;

  logic        out_ok;
  logic        fire;
  logic        finish;
  logic        closing;
  logic [7:0]  cur_byte;
  logic [31:0] crc_next;
  logic [31:0] count_next;

  assign out_ok     = !out_valid || !out_stall;
  assign fire       = out_ok && work_valid;
  assign finish     = fire && (idx == work.last_idx);
  assign closing    = work.last && (idx == work.last_idx);
  assign pop        = head_valid && (!work_valid || finish);
  assign cur_byte   = work.bytes[{idx, 3'b000} +: 8];
  assign crc_next   = rgbenc_pkg::crc32_byte(crc, cur_byte);
  assign count_next = count + 32'd1;

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= head_entry;
    end
    if (fire) begin
      out_data.out_byte       <= cur_byte;
      out_data.end_of_payload <= closing;
      out_data.image_crc      <= closing ? ~crc_next : 32'd0;
      out_data.image_length   <= closing ? count_next : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      idx        <= 3'd0;
      crc        <= rgbenc_pkg::CRC_INIT;
      count      <= 32'd0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        work_valid <= 1'b1;
        idx        <= 3'd0;
      end else if (fire) begin
        idx <= idx + 3'd1;
        if (finish) begin
          work_valid <= 1'b0;
        end
      end
      if (fire) begin
        // restart the checksum after the final byte of an image
        crc       <= closing ? rgbenc_pkg::CRC_INIT : crc_next;
        count     <= closing ? 32'd0 : count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/rgb565_rle_crc_pixel_encoder.sv
// ----------------------------------------------------------------------------
// rgb565_rle_crc_pixel_encoder: RGB565 raw / run-length encoder with CRC-32
// Pixels in, little-endian payload bytes out, CRC and length on the last byte.
// ----------------------------------------------------------------------------
// A pixel is taken every cycle while the four-entry queue between the pixel
// classifier and the byte serializer has room. Each pixel releases 0, 2, 4, 6
// or 8 payload bytes and the serializer sends one byte per cycle, so raw mode
// sends 2 bytes per pixel and run-length mode 0 to 8 bytes per pixel
// (4 when every pixel differs from the one before). The output register holds
// a word while the byte side stalls, and the serializer waits with it; the
// next byte goes out in the cycle after the stall drops.
// encoding_mode lives at byte address 0 and resets to run-length mode.
`default_nettype none

module rgb565_rle_crc_pixel_encoder (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire rgbenc_pkg::pixel_t    in_data,
  output logic                       in_stall,
  output logic                       out_valid,
  output rgbenc_pkg::out_word_t      out_data,
  input  wire logic                  out_stall,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [1:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic               encoding_mode;
  logic               accept;
  logic               push;
  rgbenc_pkg::entry_t push_entry;
  logic               pop;
  logic               head_valid;
  rgbenc_pkg::entry_t head_entry;
  logic               q_full;
  logic               q_empty;

  assign pready   = 1'b1;
  assign prdata   = (paddr == rgbenc_pkg::ADDR_ENCODING_MODE) ?
                    {31'd0, encoding_mode} : 32'd0;
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode <= rgbenc_pkg::MODE_RLE;
    end else if (psel && penable && pwrite && pready &&
                 paddr == rgbenc_pkg::ADDR_ENCODING_MODE) begin
      encoding_mode <= pwdata[0];
    end
  end

  rgbenc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .encoding_mode (encoding_mode),
    .accept        (accept),
    .pixel         (in_data),
    .push          (push),
    .entry         (push_entry)
  );

  rgbenc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  rgbenc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

  // CRC and length appear only on the closing word
  a_fields_zero_midstream: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.end_of_payload) |->
      (out_data.image_crc == 32'd0 && out_data.image_length == 32'd0))
    else $error("crc or length set on a word that does not close the payload");

  // every record is a whole number of 16-bit halves
  a_length_even: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.end_of_payload) |-> (out_data.image_length[0] == 1'b0))
    else $error("odd payload length");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !in_stall)
    else $error("input stalled with an empty queue");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("queue push while full");

endmodule

`default_nettype wire
